// ===== rtl/tnmb_pkg.sv =====
// Package for the timestamp nearest-match buffer.
// Holds the store geometry, record and memory-port types, action codes and
// sequencer states. No dependencies.
package tnmb_pkg;

	localparam int DEPTH = 256;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;

	localparam logic [31:0]   TOL_RESET  = 32'd1000000000;
	localparam logic [CW-1:0] KEEP_RESET = CW'(1);

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_REQ   = 2'd1,
		ACT_CLEAN = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic {
		CFG_TOL  = 1'b0,
		CFG_KEEP = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [63:0] stamp;
		logic [31:0] span;
		logic [31:0] frame;
	} record_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		record_t       wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ADD,
		S_RQ_RD,
		S_RQ_CMP,
		S_BF_RD,
		S_BF,
		S_TIE,
		S_MT_RD,
		S_MT,
		S_GAP,
		S_TOL,
		S_SPAN,
		S_CL_RD,
		S_CL,
		S_OLD_RD,
		S_OLD,
		S_NEW_RD,
		S_NEW,
		S_OUT
	} state_t;

endpackage

// ===== rtl/tnmb_store.sv =====
// Record store: one write port, one read port with registered read data.
// Depends on tnmb_pkg for DEPTH, AW and the record/port types.
module tnmb_store
	import tnmb_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output record_t  rdata
);

	record_t mem [DEPTH];
	record_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tnmb_sub.sv =====
// Shared 64-bit subtractor: difference and borrow (a < b, unsigned).
// Depends on nothing but the package import convention.
module tnmb_sub
	import tnmb_pkg::*;
(
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] diff,
	output logic        borrow
);

	logic [64:0] wide;

	assign wide   = {1'b0, a} - {1'b0, b};
	assign diff   = wide[63:0];
	assign borrow = wide[64];

endmodule

// ===== rtl/tnmb_seq.sv =====
// Sequencer and datapath registers of the nearest-match buffer.
// Drives the record store and the shared subtractor through its ports;
// depends only on tnmb_pkg (both are instantiated by the top level).
module tnmb_seq
	import tnmb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    action,
	input  logic [63:0]   stamp,
	input  logic [31:0]   valid_span,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          accepted,
	output logic          found,
	output logic [63:0]   match_stamp,
	output logic [31:0]   match_frame,
	output logic          within_tolerance,
	output logic [CW-1:0] entry_count,
	output logic [63:0]   oldest_stamp,
	output logic [63:0]   newest_stamp,
	output mem_req_t      mem_req,
	input  record_t       mem_rdata,
	output logic [63:0]   sub_a,
	output logic [63:0]   sub_b,
	input  logic [63:0]   sub_diff,
	input  logic          sub_borrow
);

	state_t state_q, state_d;

	logic [31:0]   tol_q;
	logic [CW-1:0] keep_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] held_q;
	logic [AW-1:0] cursor_q;
	logic [63:0]   matched_q;
	logic [31:0]   frame_ctr_q;

	logic [63:0]   asked_q;
	logic [31:0]   span_in_q;

	logic [63:0]   to_after_q;
	logic [63:0]   to_before_q;
	logic [63:0]   gap_q;
	logic          neg_q;
	logic          lt_tol_q;
	logic [31:0]   mspan_q;

	logic          accepted_q;
	logic          found_q;
	logic [63:0]   mstamp_q;
	logic [31:0]   mframe_q;
	logic          within_q;
	logic [63:0]   oldest_q;
	logic [63:0]   newest_q;

	logic          take;
	logic [CW-1:0] limit;
	logic [CW-1:0] cur_next;
	logic [CW-1:0] held_m1;
	logic          over_limit;

	assign take       = in_valid && (state_q == S_IDLE);
	assign limit      = (keep_q == '0) ? CW'(1) : keep_q;
	assign over_limit = held_q > limit;
	assign cur_next   = {1'b0, cursor_q} + CW'(1);
	assign held_m1    = held_q - CW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (action_t'(action))
						ACT_ADD:   state_d = S_ADD;
						ACT_REQ:   state_d = S_RQ_RD;
						ACT_CLEAN: state_d = S_CL_RD;
						default:   state_d = S_OLD_RD;
					endcase
				end
			end
			S_ADD:   state_d = S_OLD_RD;
			S_RQ_RD: begin
				if (held_q == '0) begin
					state_d = S_OLD_RD;
				end else if (held_q == CW'(1)) begin
					state_d = S_MT_RD;
				end else begin
					state_d = S_RQ_CMP;
				end
			end
			S_RQ_CMP: begin
				if (sub_borrow) begin
					state_d = (cur_next >= held_q) ? S_MT_RD : S_RQ_RD;
				end else begin
					state_d = (cursor_q == '0) ? S_MT_RD : S_BF_RD;
				end
			end
			S_BF_RD:  state_d = S_BF;
			S_BF:     state_d = S_TIE;
			S_TIE:    state_d = S_MT_RD;
			S_MT_RD:  state_d = S_MT;
			S_MT:     state_d = S_GAP;
			S_GAP:    state_d = S_TOL;
			S_TOL:    state_d = S_SPAN;
			S_SPAN:   state_d = S_OLD_RD;
			S_CL_RD:  state_d = over_limit ? S_CL : S_OLD_RD;
			S_CL:     state_d = sub_borrow ? S_CL_RD : S_OLD_RD;
			S_OLD_RD: state_d = S_OLD;
			S_OLD:    state_d = S_NEW_RD;
			S_NEW_RD: state_d = S_NEW;
			S_NEW:    state_d = S_OUT;
			S_OUT:    state_d = out_stall ? S_OUT : S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// store port and shared subtractor operands
	always_comb begin
		mem_req.we          = 1'b0;
		mem_req.waddr       = head_q + held_q[AW-1:0];
		mem_req.wdata.stamp = asked_q;
		mem_req.wdata.span  = span_in_q;
		mem_req.wdata.frame = frame_ctr_q;
		mem_req.raddr       = head_q + cursor_q;
		sub_a               = '0;
		sub_b               = '0;
		case (state_q)
			S_ADD: begin
				mem_req.we = (held_q < CW'(DEPTH));
			end
			S_RQ_CMP: begin
				sub_a = mem_rdata.stamp;
				sub_b = asked_q;
			end
			S_BF_RD: begin
				mem_req.raddr = head_q + cursor_q - AW'(1);
			end
			S_BF: begin
				sub_a = asked_q;
				sub_b = mem_rdata.stamp;
			end
			S_TIE: begin
				sub_a = to_after_q;
				sub_b = to_before_q;
			end
			S_MT: begin
				sub_a = asked_q;
				sub_b = mem_rdata.stamp;
			end
			S_GAP: begin
				// negate when the record lies after the requested time
				sub_a = neg_q ? 64'd0 : gap_q;
				sub_b = neg_q ? gap_q : 64'd0;
			end
			S_TOL: begin
				sub_a = gap_q;
				sub_b = {32'd0, tol_q};
			end
			S_SPAN: begin
				sub_a = gap_q;
				sub_b = {32'd0, mspan_q};
			end
			S_CL_RD, S_OLD_RD: begin
				mem_req.raddr = head_q;
			end
			S_CL: begin
				sub_a = mem_rdata.stamp;
				sub_b = matched_q;
			end
			S_NEW_RD: begin
				mem_req.raddr = head_q + held_m1[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tol_q       <= TOL_RESET;
			keep_q      <= KEEP_RESET;
			head_q      <= '0;
			held_q      <= '0;
			cursor_q    <= '0;
			matched_q   <= '0;
			frame_ctr_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TOL:  tol_q  <= cfg_data;
					CFG_KEEP: keep_q <= cfg_data[CW-1:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (take && action_t'(action) == ACT_CLEAR) begin
						held_q   <= '0;
						cursor_q <= '0;
					end
				end
				S_ADD: begin
					if (held_q < CW'(DEPTH)) begin
						frame_ctr_q <= frame_ctr_q + 32'd1;
						held_q      <= held_q + CW'(1);
						if (held_q == '0) begin
							cursor_q <= '0;
						end
					end
				end
				S_RQ_RD: begin
					if (held_q == '0) begin
						matched_q <= '0;
					end else if (held_q == CW'(1)) begin
						cursor_q <= '0;
					end
				end
				S_RQ_CMP: begin
					if (sub_borrow) begin
						cursor_q <= (cur_next >= held_q) ? held_m1[AW-1:0] : cur_next[AW-1:0];
					end
				end
				S_TIE: begin
					if (!sub_borrow) begin
						cursor_q <= cursor_q - AW'(1);
					end
				end
				S_MT: begin
					matched_q <= mem_rdata.stamp;
				end
				S_CL: begin
					if (sub_borrow) begin
						head_q <= head_q + AW'(1);
						held_q <= held_m1;
						if (cursor_q != '0) begin
							cursor_q <= cursor_q - AW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload and scratch registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (take) begin
					asked_q    <= stamp;
					span_in_q  <= valid_span;
					accepted_q <= 1'b1;
					found_q    <= 1'b0;
					mstamp_q   <= '0;
					mframe_q   <= '0;
					within_q   <= 1'b0;
				end
			end
			S_ADD: begin
				accepted_q <= (held_q < CW'(DEPTH));
			end
			S_RQ_RD: begin
				if (held_q == '0) begin
					accepted_q <= 1'b0;
				end
			end
			S_RQ_CMP: begin
				to_after_q <= sub_diff;
			end
			S_BF: begin
				to_before_q <= sub_diff;
			end
			S_MT: begin
				found_q  <= 1'b1;
				mstamp_q <= mem_rdata.stamp;
				mframe_q <= mem_rdata.frame;
				mspan_q  <= mem_rdata.span;
				gap_q    <= sub_diff;
				neg_q    <= sub_borrow;
			end
			S_GAP: begin
				gap_q <= sub_diff;
			end
			S_TOL: begin
				lt_tol_q <= sub_borrow;
			end
			S_SPAN: begin
				within_q <= lt_tol_q && sub_borrow;
			end
			S_OLD: begin
				oldest_q <= (held_q == '0) ? 64'd0 : mem_rdata.stamp;
			end
			S_NEW: begin
				newest_q <= (held_q == '0) ? 64'd0 : mem_rdata.stamp;
			end
			default: begin
			end
		endcase
	end

	assign in_stall         = (state_q != S_IDLE);
	assign out_valid        = (state_q == S_OUT);
	assign accepted         = accepted_q;
	assign found            = found_q;
	assign match_stamp      = mstamp_q;
	assign match_frame      = mframe_q;
	assign within_tolerance = within_q;
	assign entry_count      = held_q;
	assign oldest_stamp     = oldest_q;
	assign newest_stamp     = newest_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(DEPTH))
		else $error("record count above store depth");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != '0 |-> {1'b0, cursor_q} < held_q)
		else $error("cursor beyond the held records");

	a_refuse_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> (held_q == '0) || (held_q == CW'(DEPTH)))
		else $error("action refused while store neither empty nor full");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held_q == '0 |-> oldest_q == '0 && newest_q == '0 && !found_q)
		else $error("empty store reports records");

	a_clean_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CL && sub_borrow |=> held_q >= limit)
		else $error("clean dropped below the keep limit");

endmodule

// ===== rtl/timestamp_nearest_match_buffer.sv =====
// Timestamp nearest-match buffer, top level.
// Holds the record store, the shared subtractor and the sequencer.
// Depends on tnmb_pkg, tnmb_store, tnmb_sub and tnmb_seq.
//
// Usage: one item enters on the input channel (in_valid high, in_stall low)
// and yields exactly one result on the output channel (out_valid high,
// out_stall low). Actions: add a record, request the nearest record to a
// time, clean old records, clear the store. Tolerance and keep limit are set
// through the write port (cfg_we, cfg_index, cfg_data), only while idle by
// the user; the block does not enforce it. Items are handled one at a time
// through a single read port and one 64-bit subtractor: a clean drops
// records one by one, and a request moves the cursor over records one by
// one and may compare the earlier neighbor to pick the nearer one. The next
// item is taken in the cycle after the result transfer at the soonest.
// in_stall stays high from the cycle after a transfer until the result has
// been taken. While out_stall is high the result holds and nothing new is
// taken. Reset empties the store at once (no clearing pass), sets the
// tolerance to 1 s and the keep limit to 1; stored data need no reset.
module timestamp_nearest_match_buffer
	import tnmb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    action,
	input  logic [63:0]   stamp,
	input  logic [31:0]   valid_span,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          accepted,
	output logic          found,
	output logic [63:0]   match_stamp,
	output logic [31:0]   match_frame,
	output logic          within_tolerance,
	output logic [CW-1:0] entry_count,
	output logic [63:0]   oldest_stamp,
	output logic [63:0]   newest_stamp
);

	mem_req_t    mem_req;
	record_t     mem_rdata;
	logic [63:0] sub_a;
	logic [63:0] sub_b;
	logic [63:0] sub_diff;
	logic        sub_borrow;

	tnmb_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	tnmb_sub u_sub (
		.a      (sub_a),
		.b      (sub_b),
		.diff   (sub_diff),
		.borrow (sub_borrow)
	);

	tnmb_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.stamp            (stamp),
		.valid_span       (valid_span),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.accepted         (accepted),
		.found            (found),
		.match_stamp      (match_stamp),
		.match_frame      (match_frame),
		.within_tolerance (within_tolerance),
		.entry_count      (entry_count),
		.oldest_stamp     (oldest_stamp),
		.newest_stamp     (newest_stamp),
		.mem_req          (mem_req),
		.mem_rdata        (mem_rdata),
		.sub_a            (sub_a),
		.sub_b            (sub_b),
		.sub_diff         (sub_diff),
		.sub_borrow       (sub_borrow)
	);

endmodule
